// ----- sv/ecpa_pkg.sv -----
package ecpa_pkg;

    typedef enum logic [1:0] {
        MOD_REDUCE = 2'd0,
        MOD_MUL    = 2'd1,
        MOD_INV    = 2'd2
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RED,
        ST_CHK,
        ST_SLOPE,
        ST_INV,
        ST_M,
        ST_X3,
        ST_Y3,
        ST_OUT
    } t_state;

    localparam logic [1:0] REG_MODULUS = 2'd0;
    localparam logic [1:0] REG_COEFF_A = 2'd1;
    localparam logic [1:0] REG_COEFF_B = 2'd2;

endpackage

// ----- sv/ecpa_if.sv -----
interface ecpa_in_if #(parameter int FIELD_BITS = 16);
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] first_x;
    logic [FIELD_BITS-1:0] first_y;
    logic                  first_at_infinity;
    logic [FIELD_BITS-1:0] second_x;
    logic [FIELD_BITS-1:0] second_y;
    logic                  second_at_infinity;
    modport source (output valid, first_x, first_y, first_at_infinity,
                    second_x, second_y, second_at_infinity, input ready);
    modport sink (input valid, first_x, first_y, first_at_infinity,
                  second_x, second_y, second_at_infinity, output ready);
endinterface

interface ecpa_out_if #(parameter int FIELD_BITS = 16);
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] sum_x;
    logic [FIELD_BITS-1:0] sum_y;
    logic                  sum_at_infinity;
    logic                  not_on_curve;
    modport source (output valid, sum_x, sum_y, sum_at_infinity, not_on_curve,
                    input ready);
    modport sink (input valid, sum_x, sum_y, sum_at_infinity, not_on_curve,
                  output ready);
endinterface

// ----- sv/ec_point_add_mod_p_core.sv -----
// Adds two affine points on y^2 = x^3 + a*x + b modulo a configured prime. One
// beat in gives one beat out; the block takes no new beat while it computes,
// but a finished sum waits in its own output register so the next beat can be
// taken meanwhile. Reductions, multiplies and inverses share one modular unit;
// additions and subtractions are done inline, and the inverse runs Euclid's
// algorithm. An addition of finite points takes at most 12 multiplies plus one
// inverse after six input reductions; infinity operands need only the six
// input reductions.
module ec_point_add_mod_p_core #(
    parameter int FIELD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [FIELD_BITS-1:0] i_cfg_data,
    ecpa_in_if.sink               in_if,
    ecpa_out_if.source            out_if
);
    localparam int W = FIELD_BITS;

    ecpa_pkg::t_state r_st, n_st;
    logic [W-1:0] r_p, r_ca, r_cb;
    logic [3:0]   r_step, n_step;
    logic [W-1:0] r_x1, n_x1, r_y1, n_y1, r_x2, n_x2, r_y2, n_y2;
    logic [W-1:0] r_a, n_a, r_b, n_b;
    logic [W-1:0] r_t, n_t, r_u, n_u, r_m, n_m;
    logic [W-1:0] r_rx, n_rx, r_ry, n_ry;
    logic         r_i1, n_i1, r_i2, n_i2;
    logic         r_inf, n_inf, r_bad, n_bad;
    logic [W-1:0] r_ox, n_ox, r_oy, n_oy;
    logic         r_oinf, n_oinf, r_obad, n_obad;
    logic         r_busy, n_busy;
    logic         r_ovld, n_ovld;
    logic         w_start;
    ecpa_pkg::t_op w_op;
    logic [W-1:0] w_ua, w_ub, w_res, w_p;
    logic         w_done;

    assign w_p = (r_p < W'(2)) ? W'(2) : r_p;

    ecpa_mod_unit #(.FIELD_BITS(W)) u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_op(w_op),
        .i_a(w_ua), .i_b(w_ub), .i_p(w_p), .o_done(w_done), .o_res(w_res)
    );

    function automatic logic [W-1:0] f_add(input logic [W-1:0] u, v, p);
        logic [W:0] s;
        s = {1'b0, u} + {1'b0, v};
        if (s >= {1'b0, p}) s = s - {1'b0, p};
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] f_sub(input logic [W-1:0] u, v, p);
        logic [W:0] s;
        s = {1'b0, u} + {1'b0, p} - {1'b0, v};
        if (s >= {1'b0, p}) s = s - {1'b0, p};
        return s[W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ecpa_pkg::ST_IDLE;
            r_p    <= W'(2);
            r_ca   <= '0;
            r_cb   <= '0;
            r_busy <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_busy <= n_busy;
            r_ovld <= n_ovld;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ecpa_pkg::REG_MODULUS: r_p  <= i_cfg_data;
                    ecpa_pkg::REG_COEFF_A: r_ca <= i_cfg_data;
                    ecpa_pkg::REG_COEFF_B: r_cb <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_step <= n_step;
        r_x1 <= n_x1; r_y1 <= n_y1; r_x2 <= n_x2; r_y2 <= n_y2;
        r_a <= n_a; r_b <= n_b; r_t <= n_t; r_u <= n_u; r_m <= n_m;
        r_rx <= n_rx; r_ry <= n_ry; r_i1 <= n_i1; r_i2 <= n_i2;
        r_inf <= n_inf; r_bad <= n_bad;
        r_ox <= n_ox; r_oy <= n_oy; r_oinf <= n_oinf; r_obad <= n_obad;
    end

    assign in_if.ready     = (r_st == ecpa_pkg::ST_IDLE);
    assign out_if.valid    = r_ovld;
    assign out_if.sum_x    = r_ox;
    assign out_if.sum_y    = r_oy;
    assign out_if.sum_at_infinity = r_oinf;
    assign out_if.not_on_curve    = r_obad;

    always_comb begin
        n_st = r_st; n_step = r_step;
        n_x1 = r_x1; n_y1 = r_y1; n_x2 = r_x2; n_y2 = r_y2;
        n_a = r_a; n_b = r_b; n_t = r_t; n_u = r_u; n_m = r_m;
        n_rx = r_rx; n_ry = r_ry; n_i1 = r_i1; n_i2 = r_i2;
        n_inf = r_inf; n_bad = r_bad; n_ovld = r_ovld;
        n_ox = r_ox; n_oy = r_oy; n_oinf = r_oinf; n_obad = r_obad;
        n_busy = r_busy;
        w_start = 1'b0; w_op = ecpa_pkg::MOD_MUL; w_ua = '0; w_ub = '0;
        if (r_ovld && out_if.ready) n_ovld = 1'b0;

        // Issue one operation per step; r_busy marks it in flight.
        if (r_busy && w_done) n_busy = 1'b0;

        unique case (r_st)
            ecpa_pkg::ST_IDLE: begin
                if (in_if.valid) begin
                    n_x1 = in_if.first_x;  n_y1 = in_if.first_y;
                    n_x2 = in_if.second_x; n_y2 = in_if.second_y;
                    n_i1 = in_if.first_at_infinity;
                    n_i2 = in_if.second_at_infinity;
                    n_step = '0;
                    n_st = ecpa_pkg::ST_RED;
                end
            end
            ecpa_pkg::ST_RED: begin
                w_op = ecpa_pkg::MOD_REDUCE;
                unique case (r_step)
                    4'd0: w_ub = r_x1;
                    4'd1: w_ub = r_y1;
                    4'd2: w_ub = r_x2;
                    4'd3: w_ub = r_y2;
                    4'd4: w_ub = r_ca;
                    default: w_ub = r_cb;
                endcase
                if (!r_busy) begin
                    w_start = 1'b1; n_busy = 1'b1;
                end else if (w_done) begin
                    unique case (r_step)
                        4'd0: n_x1 = w_res;
                        4'd1: n_y1 = w_res;
                        4'd2: n_x2 = w_res;
                        4'd3: n_y2 = w_res;
                        4'd4: n_a  = w_res;
                        default: n_b = w_res;
                    endcase
                    n_step = r_step + 4'd1;
                    if (r_step == 4'd5) begin
                        n_step = '0;
                        n_inf = 1'b0; n_bad = 1'b0; n_rx = '0; n_ry = '0;
                        if (r_i1 || r_i2) begin
                            n_st = ecpa_pkg::ST_OUT;
                            if (r_i1 && r_i2) n_inf = 1'b1;
                            else if (r_i1) begin n_rx = r_x2; n_ry = r_y2; end
                            else begin n_rx = r_x1; n_ry = r_y1; end
                        end else begin
                            n_st = ecpa_pkg::ST_CHK;
                        end
                    end
                end
            end
            ecpa_pkg::ST_CHK: begin
                // Per point: t=x*x, t=t*x, t=t+a*x+b, then compare y*y with t.
                unique case (r_step[1:0])
                    2'd0: begin w_ua = r_step[2] ? r_x2 : r_x1; w_ub = w_ua; end
                    2'd1: begin w_ua = r_t; w_ub = r_step[2] ? r_x2 : r_x1; end
                    2'd2: begin w_ua = r_a; w_ub = r_step[2] ? r_x2 : r_x1; end
                    default: begin w_ua = r_step[2] ? r_y2 : r_y1; w_ub = w_ua; end
                endcase
                if (!r_busy) begin
                    w_start = 1'b1; n_busy = 1'b1;
                end else if (w_done) begin
                    n_step = r_step + 4'd1;
                    unique case (r_step[1:0])
                        2'd0, 2'd1: n_t = w_res;
                        2'd2: n_t = f_add(f_add(r_t, w_res, w_p), r_b, w_p);
                        default: begin
                            if (w_res != r_t) n_bad = 1'b1;
                            if (r_step == 4'd7) begin
                                n_step = '0;
                                if (n_bad) n_st = ecpa_pkg::ST_OUT;
                                else if (r_x1 == r_x2 && (r_y1 != r_y2 || r_y1 == '0)) begin
                                    n_inf = 1'b1; n_st = ecpa_pkg::ST_OUT;
                                end else if (r_x1 == r_x2) begin
                                    n_st = ecpa_pkg::ST_SLOPE;
                                end else begin
                                    n_t = f_sub(r_y2, r_y1, w_p);
                                    n_u = f_sub(r_x2, r_x1, w_p);
                                    n_st = ecpa_pkg::ST_INV;
                                end
                            end
                        end
                    endcase
                end
            end
            ecpa_pkg::ST_SLOPE: begin
                w_ua = r_x1; w_ub = r_x1;
                if (!r_busy) begin
                    w_start = 1'b1; n_busy = 1'b1;
                end else if (w_done) begin
                    n_t = f_add(f_add(f_add(w_res, w_res, w_p), w_res, w_p), r_a, w_p);
                    n_u = f_add(r_y1, r_y1, w_p);
                    n_st = ecpa_pkg::ST_INV;
                end
            end
            ecpa_pkg::ST_INV: begin
                w_op = ecpa_pkg::MOD_INV; w_ua = r_u;
                if (!r_busy) begin
                    w_start = 1'b1; n_busy = 1'b1;
                end else if (w_done) begin
                    n_u = w_res; n_st = ecpa_pkg::ST_M;
                end
            end
            ecpa_pkg::ST_M: begin
                w_ua = r_t; w_ub = r_u;
                if (!r_busy) begin
                    w_start = 1'b1; n_busy = 1'b1;
                end else if (w_done) begin
                    n_m = w_res; n_st = ecpa_pkg::ST_X3;
                end
            end
            ecpa_pkg::ST_X3: begin
                w_ua = r_m; w_ub = r_m;
                if (!r_busy) begin
                    w_start = 1'b1; n_busy = 1'b1;
                end else if (w_done) begin
                    n_rx = f_sub(f_sub(w_res, r_x1, w_p), r_x2, w_p);
                    n_st = ecpa_pkg::ST_Y3;
                end
            end
            ecpa_pkg::ST_Y3: begin
                w_ua = r_m; w_ub = f_sub(r_x1, r_rx, w_p);
                if (!r_busy) begin
                    w_start = 1'b1; n_busy = 1'b1;
                end else if (w_done) begin
                    n_ry = f_sub(w_res, r_y1, w_p);
                    n_st = ecpa_pkg::ST_OUT;
                end
            end
            default: begin
                if (!n_ovld) begin
                    n_ox   = (r_inf || r_bad) ? '0 : r_rx;
                    n_oy   = (r_inf || r_bad) ? '0 : r_ry;
                    n_oinf = r_inf;
                    n_obad = r_bad;
                    n_ovld = 1'b1;
                    n_st = ecpa_pkg::ST_IDLE;
                end
            end
        endcase
    end
endmodule

// ----- sv/ecpa_mod_unit.sv -----
module ecpa_mod_unit #(
    parameter int FIELD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  ecpa_pkg::t_op         i_op,
    input  logic [FIELD_BITS-1:0] i_a,
    input  logic [FIELD_BITS-1:0] i_b,
    input  logic [FIELD_BITS-1:0] i_p,
    output logic                  o_done,
    output logic [FIELD_BITS-1:0] o_res
);
    localparam int W  = FIELD_BITS;
    localparam int PW = 2 * FIELD_BITS;
    localparam int CW = $clog2(PW + 1);

    typedef enum logic [1:0] {
        U_IDLE,
        U_PROD,
        U_RED,
        U_INV
    } t_ustate;

    t_ustate       r_st, n_st;
    logic [PW-1:0] r_acc, n_acc;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_res, n_res;
    logic          r_done, n_done;
    logic [W:0]    r_r0, n_r0, r_r1, n_r1;
    logic [W:0]    r_t0, n_t0, r_t1, n_t1;
    logic [W:0]    r_q, n_q;
    logic [W:0]    r_rem, n_rem;
    logic [W-1:0]  r_mul_a;
    logic [W-1:0]  n_mul_a;
    logic [PW-1:0] w_prod;
    logic [W:0]    w_rbit;
    logic [W:0]    w_tq;
    logic [2*W+1:0] w_qt;

    assign w_prod = r_mul_a * i_b;
    assign w_rbit = {r_rem[W-1:0], r_acc[PW-1]};
    assign w_qt   = r_q * r_t1;
    assign w_tq   = r_t0 - w_qt[W:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= U_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
        r_acc   <= n_acc;
        r_cnt   <= n_cnt;
        r_res   <= n_res;
        r_r0    <= n_r0;
        r_r1    <= n_r1;
        r_t0    <= n_t0;
        r_t1    <= n_t1;
        r_q     <= n_q;
        r_rem   <= n_rem;
        r_mul_a <= n_mul_a;
    end

    // Reduction is restoring, one bit per cycle; the inverse runs Euclid with
    // one bit of each quotient per cycle.
    always_comb begin
        n_st    = r_st;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_res   = r_res;
        n_done  = 1'b0;
        n_r0    = r_r0;
        n_r1    = r_r1;
        n_t0    = r_t0;
        n_t1    = r_t1;
        n_q     = r_q;
        n_rem   = r_rem;
        n_mul_a = r_mul_a;
        unique case (r_st)
            U_IDLE: begin
                if (i_start) begin
                    unique case (i_op)
                        ecpa_pkg::MOD_MUL: begin
                            n_mul_a = i_a;
                            n_st    = U_PROD;
                        end
                        ecpa_pkg::MOD_INV: begin
                            n_r0  = {1'b0, i_p};
                            n_r1  = {1'b0, i_a};
                            n_t0  = '0;
                            n_t1  = {{W{1'b0}}, 1'b1};
                            n_acc = {{W{1'b0}}, i_p};
                            n_rem = '0;
                            n_q   = '0;
                            n_cnt = CW'(PW);
                            n_st  = U_INV;
                        end
                        default: begin
                            n_acc = {i_a, i_b};
                            n_rem = '0;
                            n_cnt = CW'(PW);
                            n_st  = U_RED;
                        end
                    endcase
                end
            end
            U_PROD: begin
                n_acc = w_prod;
                n_rem = '0;
                n_cnt = CW'(PW);
                n_st  = U_RED;
            end
            U_RED: begin
                n_acc = {r_acc[PW-2:0], 1'b0};
                if (w_rbit >= {1'b0, i_p}) begin
                    n_rem = w_rbit - {1'b0, i_p};
                end else begin
                    n_rem = w_rbit;
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_res  = n_rem[W-1:0];
                    n_done = 1'b1;
                    n_st   = U_IDLE;
                end
            end
            default: begin
                if (r_r1 == '0) begin
                    if (r_r0 == {{W{1'b0}}, 1'b1}) begin
                        if (r_t0[W]) begin
                            n_res = W'(r_t0 + {1'b0, i_p});
                        end else begin
                            n_res = r_t0[W-1:0];
                        end
                    end else begin
                        n_res = '0;
                    end
                    n_done = 1'b1;
                    n_st   = U_IDLE;
                end else if (r_cnt != '0) begin
                    // Divide r0 by r1, bit by bit from bit W-1 of r_acc.
                    n_acc = {r_acc[PW-2:0], 1'b0};
                    if ({r_rem[W-1:0], r_acc[W-1]} >= r_r1) begin
                        n_rem = {r_rem[W-1:0], r_acc[W-1]} - r_r1;
                        n_q   = {r_q[W-1:0], 1'b1};
                    end else begin
                        n_rem = {r_rem[W-1:0], r_acc[W-1]};
                        n_q   = {r_q[W-1:0], 1'b0};
                    end
                    if (r_cnt == CW'(PW)) begin
                        n_cnt = CW'(W - 1);
                    end else if (r_cnt == CW'(1)) begin
                        n_cnt = '0;
                    end else begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end else begin
                    n_r0  = r_r1;
                    n_r1  = r_rem;
                    n_t0  = r_t1;
                    n_t1  = w_tq;
                    n_acc = {{W{1'b0}}, r_r1[W-1:0]};
                    n_rem = '0;
                    n_q   = '0;
                    n_cnt = CW'(PW);
                end
            end
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule
